@@ rtl/ring_queue_with_value_purge_core_macros.svh @@
// Assertion macros for the ring queue core.
// Used by the top level only; needs no package.
`ifndef RING_QUEUE_WITH_VALUE_PURGE_CORE_MACROS_SVH
`define RING_QUEUE_WITH_VALUE_PURGE_CORE_MACROS_SVH

// same-cycle implication
`define RQVP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rqvp: same-cycle check failed");

// next-cycle implication
`define RQVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rqvp: next-cycle check failed");

`endif

@@ rtl/rqvp_pkg.sv @@
// Package for the ring queue core: sizes, command and status codes,
// request and result structs, chain control struct. No dependencies.
`timescale 1ns / 1ps

package rqvp_pkg;

	localparam int DEPTH     = 128;
	localparam int NUM_CELLS = DEPTH - 1;
	localparam int CNT_W     = $clog2(DEPTH);
	localparam int WORD_W    = 32;
	localparam int OCC_W     = 7;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PURGE = 2'd2
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_e_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_PURGE
	} fsm_state_t;

	typedef struct packed {
		cmd_e_t                    command;
		logic signed [WORD_W-1:0]  value;
	} in_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  out_value;
		status_e_t                 status;
		logic [OCC_W-1:0]          occupancy;
	} out_res_t;

	typedef struct packed {
		logic               shift;
		logic               load;
		logic [CNT_W-1:0]   load_idx;
		logic [WORD_W-1:0]  load_data;
	} chain_ctrl_t;

endpackage

@@ rtl/rqvp_cell.sv @@
// One storage cell of the queue chain: loads a word or takes its neighbor's.
// Depends on rqvp_pkg.
`timescale 1ns / 1ps

module rqvp_cell
	import rqvp_pkg::*;
(
	input  logic               clk,
	input  logic               shift_en,
	input  logic               load_en,
	input  logic [WORD_W-1:0]  load_data,
	input  logic [WORD_W-1:0]  next_data,
	output logic [WORD_W-1:0]  data
);

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			data_q <= load_data;
		end else if (shift_en) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

@@ rtl/rqvp_chain.sv @@
// Row of queue cells, oldest entry in cell 0; decodes the load position.
// Depends on rqvp_pkg and rqvp_cell.
`timescale 1ns / 1ps

module rqvp_chain
	import rqvp_pkg::*;
(
	input  logic               clk,
	input  chain_ctrl_t        ctrl,
	output logic [WORD_W-1:0]  head
);

	logic [WORD_W-1:0] cell_data [NUM_CELLS];

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		logic              load_sel;
		logic [WORD_W-1:0] next_word;

		assign load_sel = ctrl.load && (ctrl.load_idx == CNT_W'(i));

		if (i == NUM_CELLS - 1) begin : g_last
			assign next_word = cell_data[i];
		end else begin : g_mid
			assign next_word = cell_data[i+1];
		end

		rqvp_cell u_cell (
			.clk       (clk),
			.shift_en  (ctrl.shift),
			.load_en   (load_sel),
			.load_data (ctrl.load_data),
			.next_data (next_word),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

@@ rtl/ring_queue_with_value_purge_core.sv @@
// Top level of the ring queue with purge by value: control, count, result register.
// Depends on rqvp_pkg, rqvp_chain and the assertion macro header.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | in_req  (command, value)
//   out     | out_valid / out_ready| out_res (out_value, status, occupancy)
//
// Push and pop each load a result when taken; a new request is taken every cycle
// outside a purge while the result register drains. A purge accepts the request,
// then moves each stored entry past the head, reloading kept entries at the tail and
// dropping matches, then loads the result. in_ready stays low from the accept until then.
// Reset clears the count, the state and the result valid; cell contents are
// undefined until written. A stalled result holds and blocks new requests.
`timescale 1ns / 1ps
`include "ring_queue_with_value_purge_core_macros.svh"

module ring_queue_with_value_purge_core
	import rqvp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_req_t   in_req,
	output logic      out_valid,
	input  logic      out_ready,
	output out_res_t  out_res
);

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_CELLS);

	fsm_state_t         state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   remain_q, remain_d;
	logic [WORD_W-1:0]  purge_val_q;
	logic               out_valid_q;
	out_res_t           out_res_q, res_d;
	logic               res_load;
	logic               out_free;
	logic               in_acc;
	logic               push_take;
	logic               pop_miss;
	logic [WORD_W-1:0]  head;
	chain_ctrl_t        ctrl;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == FSM_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;

	assign push_take = in_acc && in_req.command == CMD_PUSH && count_q != CNT_FULL;
	assign pop_miss  = in_acc && in_req.command == CMD_POP && count_q == '0;

	rqvp_chain u_chain (
		.clk  (clk),
		.ctrl (ctrl),
		.head (head)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_acc && in_req.command == CMD_PURGE) begin
					state_d = FSM_PURGE;
				end
			end
			FSM_PURGE: begin
				if (remain_q == '0 && out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		ctrl          = '0;
		count_d       = count_q;
		remain_d      = remain_q;
		res_load      = 1'b0;
		res_d         = '0;
		res_d.status  = ST_OK;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_acc) begin
					res_load = 1'b1;
					case (in_req.command)
						CMD_PUSH: begin
							if (count_q == CNT_FULL) begin
								res_d.status = ST_FULL;
							end else begin
								ctrl.load      = 1'b1;
								ctrl.load_idx  = count_q;
								ctrl.load_data = in_req.value;
								count_d        = count_q + 1'b1;
							end
						end
						CMD_POP: begin
							if (count_q == '0) begin
								res_d.out_value = -32'sd1;
								res_d.status    = ST_EMPTY;
							end else begin
								res_d.out_value = signed'(head);
								ctrl.shift      = 1'b1;
								count_d         = count_q - 1'b1;
							end
						end
						CMD_PURGE: begin
							res_load = 1'b0;
							remain_d = count_q;
						end
						default: ;
					endcase
				end
			end
			FSM_PURGE: begin
				if (remain_q != '0) begin
					ctrl.shift = 1'b1;
					remain_d   = remain_q - 1'b1;
					if (head != purge_val_q) begin
						ctrl.load      = 1'b1;
						ctrl.load_idx  = count_q - 1'b1;
						ctrl.load_data = head;
					end else begin
						count_d = count_q - 1'b1;
					end
				end else if (out_free) begin
					res_load = 1'b1;
				end
			end
			default: ;
		endcase
		res_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_res_q <= res_d;
		end
		if (in_acc && in_req.command == CMD_PURGE) begin
			purge_val_q <= in_req.value;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`RQVP_ASSERT_IMPL(a_count_max, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	`RQVP_ASSERT_IMPL(a_purge_kept, clk, arst_n, state_q == FSM_PURGE, count_q >= remain_q)
	`RQVP_ASSERT_NEXT(a_push_grows, clk, arst_n, push_take, count_q == $past(count_q) + 1'b1)
	`RQVP_ASSERT_NEXT(a_pop_empty, clk, arst_n, pop_miss, out_valid && out_res.status == ST_EMPTY)

endmodule
